### rtl/core/vacg_pkg.sv
`default_nettype none
package vacg_pkg;

  localparam int MAX_CHUNK_SAMPLES_DEF = 512;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEVEL        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_WINDOW_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_STOP_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CAPTURE_BYTES = 3'd4;

  localparam logic [15:0] TRIGGER_LEVEL_RST     = 16'd2200;
  localparam logic [15:0] HOLD_LEVEL_RST        = 16'd900;
  localparam logic [15:0] ARM_WINDOW_MS_RST     = 16'd5000;
  localparam logic [15:0] SILENCE_STOP_MS_RST   = 16'd1400;
  localparam logic [31:0] MIN_CAPTURE_BYTES_RST = 32'd57600;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_STOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  // First member lands in the highest bits of the packed vector.
  typedef struct packed {
    logic [31:0] captured_bytes;
    logic        clip_captured;
    logic        window_expired;
    logic        capture_stopped;
    logic        capture_started;
    logic        voice_triggered;
    logic        capturing;
    logic        armed;
    logic [15:0] chunk_level;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/voice_activated_capture_gate.sv
`default_nettype none
// Channel  Direction  tdata (low bit up)                            tuser / tlast
// in_      slave      sample[15:0], now_ms[47:16]                   kind[1:0] / last_in_chunk
// out_     master     chunk_level[15:0], flags[22:16], bytes[54:23] none / none
// cfg_     write      cfg_we, cfg_index (register), cfg_wdata       none
//
// Commands and samples that do not end a chunk produce their result directly.
// A chunk-ending sample holds off new requests through ST_DIV and ST_FIN:
// the mean level comes from a restoring divider that forms one quotient bit
// per cycle, SW = 15 + clog2(MAX_CHUNK_SAMPLES + 1) bits.
// Reset is synchronous; all but the divider and result registers reset to defaults.
// A stalled output holds the finished result and blocks new requests.
module voice_activated_capture_gate #(
  parameter int MAX_CHUNK_SAMPLES = vacg_pkg::MAX_CHUNK_SAMPLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [47:0]                    in_tdata,  // sample[15:0], now_ms[47:16]
  input  wire logic [1:0]                     in_tuser,  // kind[1:0]
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [55:0]                         out_tdata, // chunk_level[15:0], armed,
                                                         // capturing, voice_triggered,
                                                         // capture_started, capture_stopped,
                                                         // window_expired, clip_captured,
                                                         // captured_bytes[54:23]
  input  wire logic                           cfg_we,
  input  wire logic [vacg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vacg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vacg_pkg::*;

  localparam int CW = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int SW = 15 + CW;
  localparam int DW = $clog2(SW + 1);

  state_t state_r, state_nxt;

  logic [15:0] trigger_level_r, hold_level_r, arm_window_r, silence_stop_r;
  logic [31:0] min_bytes_r;

  logic        armed_r, armed_nxt;
  logic        capture_r, capture_nxt;
  logic        voice_r, voice_nxt;
  logic        clip_r, clip_nxt;
  logic [31:0] arm_time_r, arm_time_nxt;
  logic [31:0] speech_time_r, speech_time_nxt;
  logic [15:0] last_level_r, last_level_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;
  logic [SW-1:0] abs_sum_r, abs_sum_nxt;
  logic [CW-1:0] sample_count_r, sample_count_nxt;
  logic [31:0] now_r;

  // Serial divider.
  logic [SW-1:0] quo_r;
  logic [CW-1:0] rem_r, den_r;
  logic [DW-1:0] div_cnt_r;
  logic [CW:0]   trial;
  logic          q_bit;
  logic [CW-1:0] rem_step;

  logic    out_valid_r;
  result_t out_r, out_nxt;
  logic    load_out, out_free, in_fire;
  logic    ev_started, ev_stopped, ev_expired, stop_req;

  logic [15:0]   in_sample;
  logic [31:0]   in_now;
  kind_t         in_kind;
  logic [15:0]   mag;
  logic          room;
  logic [SW-1:0] sum_upd;
  logic [CW-1:0] cnt_upd;
  logic [15:0]   level;
  logic [31:0]   chunk_bytes;
  logic [32:0]   byte_sum;
  logic [31:0]   bytes_sat;

  assign in_sample = in_tdata[15:0];
  assign in_now    = in_tdata[47:16];
  assign in_kind   = kind_t'(in_tuser);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Magnitude of -32768 wraps to 0x8000, which reads as 32768 unsigned.
  assign mag     = in_sample[15] ? (~in_sample + 16'd1) : in_sample;
  assign room    = sample_count_r < CW'(MAX_CHUNK_SAMPLES);
  assign sum_upd = room ? abs_sum_r + SW'(mag) : abs_sum_r;
  assign cnt_upd = room ? sample_count_r + CW'(1) : sample_count_r;

  assign trial    = {rem_r, quo_r[SW-1]};
  assign q_bit    = trial >= {1'b0, den_r};
  assign rem_step = q_bit ? CW'(trial - {1'b0, den_r}) : trial[CW-1:0];

  assign level       = (den_r == '0) ? 16'd0 : quo_r[15:0];
  assign chunk_bytes = {{(31 - CW){1'b0}}, den_r, 1'b0};
  assign byte_sum    = {1'b0, byte_count_r} + {1'b0, chunk_bytes};
  assign bytes_sat   = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];

  always_comb begin
    state_nxt        = state_r;
    armed_nxt        = armed_r;
    capture_nxt      = capture_r;
    voice_nxt        = voice_r;
    clip_nxt         = clip_r;
    arm_time_nxt     = arm_time_r;
    speech_time_nxt  = speech_time_r;
    last_level_nxt   = last_level_r;
    byte_count_nxt   = byte_count_r;
    abs_sum_nxt      = abs_sum_r;
    sample_count_nxt = sample_count_r;
    load_out         = 1'b0;
    ev_started       = 1'b0;
    ev_expired       = 1'b0;
    ev_stopped       = 1'b0;
    stop_req         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_SAMPLE: begin
              if (in_tlast) begin
                abs_sum_nxt      = '0;
                sample_count_nxt = '0;
                state_nxt        = ST_DIV;
              end else begin
                abs_sum_nxt      = sum_upd;
                sample_count_nxt = cnt_upd;
                load_out         = 1'b1;
              end
            end
            KIND_ARM: begin
              clip_nxt        = 1'b0;
              voice_nxt       = 1'b0;
              armed_nxt       = 1'b1;
              arm_time_nxt    = in_now;
              speech_time_nxt = in_now;
              last_level_nxt  = '0;
              load_out        = 1'b1;
            end
            KIND_CANCEL: begin
              armed_nxt      = 1'b0;
              voice_nxt      = 1'b0;
              last_level_nxt = '0;
              load_out       = 1'b1;
            end
            KIND_STOP: begin
              stop_req = 1'b1;
              load_out = 1'b1;
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      ST_DIV: begin
        if (div_cnt_r == DW'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load_out       = 1'b1;
          state_nxt      = ST_IDLE;
          last_level_nxt = level;
          if (armed_r && !capture_r) begin
            if (now_r - arm_time_r >= {16'd0, arm_window_r}) begin
              armed_nxt  = 1'b0;
              ev_expired = 1'b1;
            end else if (level >= trigger_level_r) begin
              voice_nxt       = 1'b1;
              speech_time_nxt = now_r;
              byte_count_nxt  = chunk_bytes;
              capture_nxt     = 1'b1;
              ev_started      = 1'b1;
            end
          end else if (capture_r) begin
            byte_count_nxt = bytes_sat;
            if (voice_r) begin
              if (level >= hold_level_r) begin
                speech_time_nxt = now_r;
              end else if (now_r - speech_time_r >= {16'd0, silence_stop_r} &&
                           bytes_sat >= min_bytes_r) begin
                stop_req = 1'b1;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Ending a capture sees the byte count of this same request.
    if (stop_req && capture_r) begin
      capture_nxt = 1'b0;
      ev_stopped  = 1'b1;
      if (byte_count_nxt != '0 && voice_nxt) begin
        clip_nxt  = 1'b1;
        voice_nxt = 1'b0;
        armed_nxt = 1'b0;
      end
    end

    out_nxt.chunk_level     = last_level_nxt;
    out_nxt.armed           = armed_nxt;
    out_nxt.capturing       = capture_nxt;
    out_nxt.voice_triggered = voice_nxt;
    out_nxt.capture_started = ev_started;
    out_nxt.capture_stopped = ev_stopped;
    out_nxt.window_expired  = ev_expired;
    out_nxt.clip_captured   = clip_nxt;
    out_nxt.captured_bytes  = byte_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      armed_r        <= 1'b0;
      capture_r      <= 1'b0;
      voice_r        <= 1'b0;
      clip_r         <= 1'b0;
      arm_time_r     <= '0;
      speech_time_r  <= '0;
      last_level_r   <= '0;
      byte_count_r   <= '0;
      abs_sum_r      <= '0;
      sample_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      armed_r        <= armed_nxt;
      capture_r      <= capture_nxt;
      voice_r        <= voice_nxt;
      clip_r         <= clip_nxt;
      arm_time_r     <= arm_time_nxt;
      speech_time_r  <= speech_time_nxt;
      last_level_r   <= last_level_nxt;
      byte_count_r   <= byte_count_nxt;
      abs_sum_r      <= abs_sum_nxt;
      sample_count_r <= sample_count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_level_r <= TRIGGER_LEVEL_RST;
      hold_level_r    <= HOLD_LEVEL_RST;
      arm_window_r    <= ARM_WINDOW_MS_RST;
      silence_stop_r  <= SILENCE_STOP_MS_RST;
      min_bytes_r     <= MIN_CAPTURE_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_LEVEL:     trigger_level_r <= cfg_wdata[15:0];
        REG_HOLD_LEVEL:        hold_level_r    <= cfg_wdata[15:0];
        REG_ARM_WINDOW_MS:     arm_window_r    <= cfg_wdata[15:0];
        REG_SILENCE_STOP_MS:   silence_stop_r  <= cfg_wdata[15:0];
        REG_MIN_CAPTURE_BYTES: min_bytes_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Divider and result registers carry payload only.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
    if (state_r == ST_IDLE && in_fire && in_kind == KIND_SAMPLE && in_tlast) begin
      quo_r     <= sum_upd;
      den_r     <= cnt_upd;
      rem_r     <= '0;
      div_cnt_r <= DW'(SW);
      now_r     <= in_now;
    end else if (state_r == ST_DIV) begin
      quo_r     <= {quo_r[SW-2:0], q_bit};
      rem_r     <= rem_step;
      div_cnt_r <= div_cnt_r - DW'(1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r};

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> (den_r == '0 || rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sample_count_r <= CW'(MAX_CHUNK_SAMPLES))
    else $error("chunk sample count past its limit");

  a_start_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.capture_started |-> out_r.capturing && out_r.voice_triggered)
    else $error("capture start without voice capture");

  a_stop_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.capture_stopped || out_r.window_expired) |-> !out_r.capturing)
    else $error("stop or expiry reported while capturing");

  a_fin_leads_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_free |=> state_r == ST_IDLE && out_valid_r)
    else $error("finished chunk did not produce a result");

endmodule
`default_nettype wire
